// File: rtl/bmg_pkg.sv
// bmg_pkg: constants, tables and elaboration-time helpers for the gaussian pair pipeline
// used by box_muller_gaussian_pair; no dependencies

package bmg_pkg;

  localparam int LOG_STEPS    = 32;
  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 30;

  // ln 2 in Q32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  // cordic start x, 1/gain in Q30
  localparam logic signed [32:0] CORDIC_X0 = 33'sh026DD3B6A;

  // cordic step angles in turns, Q32
  localparam logic [29:0] TURN_TAB [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  // log2 in Q32 with 5 integer bits, evaluated at elaboration only
  function automatic logic [36:0] log2_q32(input logic [31:0] w);
    logic [4:0]  e;
    logic [63:0] m;
    logic [31:0] frac;
    e    = 5'd0;
    frac = 32'd0;
    for (int b = 0; b < 32; b++) begin
      if (w[b]) begin
        e = 5'(b);
      end
    end
    m = 64'(w) << (31 - e);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[31-i] = 1'b1;
      end
    end
    return {e, frac};
  endfunction

  // log2 of the largest uniform word
  localparam logic [36:0] LOG2_MAX = log2_q32(32'hFFFFFFFF);

endpackage

// File: rtl/box_muller_gaussian_pair.sv
// box_muller_gaussian_pair: pipelined box-muller gaussian pair generator
// depends on bmg_pkg for constants, cordic table and the log2 of the full-scale word
//
// usage: drive in_u1_word / in_u2_word with start high for one cycle per request;
// busy is always low, so a request may be issued every clock. a request whose
// radius word is zero is dropped and gives no result.
// each result appears on out_z_cos / out_z_sin for one cycle with out_valid high,
// once the request has passed through all 71 register stages.
// throughput: one pair per clock, set by fully unrolled stages: one register stage
// per log2 squaring step (32), per square-root bit (32) and per cordic step (30),
// plus input, normalize, log scaling, trig multiply and rounding stages.
// the angle path (quadrant fold, cordic, quadrant swap) runs beside the square
// root and meets the radius at the output multiply.
// reset (rst_n low at a clock edge) clears all in-flight valid bits; requests in
// the pipe are discarded. the receiver cannot stall, so results are never held.
// outputs are signed fixed point with FRAC_BITS fraction bits.

module box_muller_gaussian_pair #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_u1_word,
  input  logic [31:0]        in_u2_word,
  output logic               out_valid,
  output logic signed [31:0] out_z_cos,
  output logic signed [31:0] out_z_sin
);

  localparam int LOGN   = bmg_pkg::LOG_STEPS;
  localparam int SQN    = bmg_pkg::SQRT_STEPS;
  localparam int CRN    = bmg_pkg::CORDIC_STEPS;
  // stage index where the radius is final
  localparam int RAD_STG = 1 + LOGN + 3 + SQN;
  localparam int LAT     = RAD_STG + 3;
  localparam int W2_DLY  = RAD_STG - CRN - 2;
  localparam int SH      = 58 - FRAC_BITS;

  assign busy = 1'b0;

  // valid chain
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start && (in_u1_word != 32'd0)};
    end
  end

  // input stage
  logic [31:0] w1_r, w2_r;
  always_ff @(posedge clk) begin
    w1_r <= in_u1_word;
    w2_r <= in_u2_word;
  end

  // normalize: msb position and left-justified mantissa
  logic [4:0]  norm_e_nxt, norm_e_r;
  logic [31:0] norm_m_r;
  always_comb begin
    norm_e_nxt = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (w1_r[b]) begin
        norm_e_nxt = 5'(b);
      end
    end
  end
  always_ff @(posedge clk) begin
    norm_e_r <= norm_e_nxt;
    norm_m_r <= w1_r << (5'd31 - norm_e_nxt);
  end

  // log2 fraction by repeated squaring, one bit per stage
  logic [31:0] sq_m_r [LOGN];
  logic [31:0] sq_f_r [LOGN];
  logic [4:0]  sq_e_r [LOGN];
  for (genvar k = 0; k < LOGN; k++) begin : g_sq
    logic [31:0] m_in, f_in;
    logic [4:0]  e_in;
    logic [63:0] prod;
    logic [32:0] t;
    if (k == 0) begin : g_first
      assign m_in = norm_m_r;
      assign f_in = 32'd0;
      assign e_in = norm_e_r;
    end else begin : g_rest
      assign m_in = sq_m_r[k-1];
      assign f_in = sq_f_r[k-1];
      assign e_in = sq_e_r[k-1];
    end
    assign prod = 64'(m_in) * 64'(m_in);
    assign t    = prod[63:31];
    always_ff @(posedge clk) begin
      sq_e_r[k] <= e_in;
      if (t[32]) begin
        sq_m_r[k] <= t[32:1];
        sq_f_r[k] <= f_in | (32'd1 << (31 - k));
      end else begin
        sq_m_r[k] <= t[31:0];
        sq_f_r[k] <= f_in;
      end
    end
  end

  // distance from full-scale log2
  logic [36:0] lw;
  logic [36:0] d_r;
  assign lw = {sq_e_r[LOGN-1], sq_f_r[LOGN-1]};
  always_ff @(posedge clk) begin
    d_r <= (lw > bmg_pkg::LOG2_MAX) ? 37'd0 : bmg_pkg::LOG2_MAX - lw;
  end

  // scale by ln 2
  logic [36:0] ln_hi_r;
  logic [63:0] ln_lo_r;
  always_ff @(posedge clk) begin
    ln_hi_r <= 37'(d_r[36:32]) * 37'(bmg_pkg::LN2_Q32);
    ln_lo_r <= 64'(d_r[31:0]) * 64'(bmg_pkg::LN2_Q32);
  end

  // square root operand: 2*ln << 24
  logic [37:0] ln_sum;
  logic [63:0] sr_rem0_r;
  assign ln_sum = 38'(ln_hi_r) + 38'(ln_lo_r[63:32]);
  always_ff @(posedge clk) begin
    sr_rem0_r <= 64'(ln_sum) << 25;
  end

  // integer square root, one result bit per stage
  logic [63:0] sr_rem_r [SQN];
  logic [63:0] sr_res_r [SQN];
  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] rem_in, res_in, trial;
    if (j == 0) begin : g_first
      assign rem_in = sr_rem0_r;
      assign res_in = 64'd0;
    end else begin : g_rest
      assign rem_in = sr_rem_r[j-1];
      assign res_in = sr_res_r[j-1];
    end
    assign trial = res_in + BIT;
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        sr_rem_r[j] <= rem_in - trial;
        sr_res_r[j] <= (res_in >> 1) + BIT;
      end else begin
        sr_rem_r[j] <= rem_in;
        sr_res_r[j] <= res_in >> 1;
      end
    end
  end

  // angle word delay to line up with the square root
  logic [31:0] w2_d_r [W2_DLY];
  for (genvar k = 0; k < W2_DLY; k++) begin : g_w2d
    always_ff @(posedge clk) begin
      if (k == 0) begin
        w2_d_r[k] <= w2_r;
      end else begin
        w2_d_r[k] <= w2_d_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // phase, quadrant fold and residual angle
  logic [31:0] phase, phase_off, ua;
  logic [1:0]  quad;
  logic [1:0]  quad_r;
  logic signed [33:0] ang0_r;
  assign phase     = (&w2_d_r[W2_DLY-1]) ? 32'd0 : w2_d_r[W2_DLY-1];
  assign phase_off = phase + 32'h2000_0000;
  assign quad      = phase_off[31:30];
  assign ua        = phase - {quad, 30'd0};
  always_ff @(posedge clk) begin
    quad_r <= quad;
    ang0_r <= 34'(signed'(ua));
  end

  // cordic rotation, one step per stage
  logic signed [32:0] cx_r [CRN];
  logic signed [32:0] cy_r [CRN];
  logic signed [33:0] ca_r [CRN];
  logic [1:0]         cq_r [CRN];
  for (genvar i = 0; i < CRN; i++) begin : g_cordic
    logic signed [32:0] x_in, y_in;
    logic signed [33:0] a_in;
    logic [1:0]         q_in;
    logic signed [33:0] step;
    if (i == 0) begin : g_first
      assign x_in = bmg_pkg::CORDIC_X0;
      assign y_in = 33'sd0;
      assign a_in = ang0_r;
      assign q_in = quad_r;
    end else begin : g_rest
      assign x_in = cx_r[i-1];
      assign y_in = cy_r[i-1];
      assign a_in = ca_r[i-1];
      assign q_in = cq_r[i-1];
    end
    assign step = signed'(34'(bmg_pkg::TURN_TAB[i]));
    always_ff @(posedge clk) begin
      cq_r[i] <= q_in;
      if (!a_in[33]) begin
        cx_r[i] <= x_in - (y_in >>> i);
        cy_r[i] <= y_in + (x_in >>> i);
        ca_r[i] <= a_in - step;
      end else begin
        cx_r[i] <= x_in + (y_in >>> i);
        cy_r[i] <= y_in - (x_in >>> i);
        ca_r[i] <= a_in + step;
      end
    end
  end

  // quadrant swap
  logic signed [33:0] tc_r, ts_r;
  logic signed [33:0] c_ext, s_ext;
  assign c_ext = 34'(cx_r[CRN-1]);
  assign s_ext = 34'(cy_r[CRN-1]);
  always_ff @(posedge clk) begin
    case (cq_r[CRN-1])
      2'd0: begin
        tc_r <= c_ext;
        ts_r <= s_ext;
      end
      2'd1: begin
        tc_r <= -s_ext;
        ts_r <= c_ext;
      end
      2'd2: begin
        tc_r <= -c_ext;
        ts_r <= -s_ext;
      end
      default: begin
        tc_r <= s_ext;
        ts_r <= -c_ext;
      end
    endcase
  end

  // radius times trig magnitude
  logic [31:0] radius, mag_c, mag_s;
  logic [63:0] prod_c_r, prod_s_r;
  logic        neg_c_r, neg_s_r;
  assign radius = sr_res_r[SQN-1][31:0];
  assign mag_c  = tc_r[33] ? 32'(-tc_r) : tc_r[31:0];
  assign mag_s  = ts_r[33] ? 32'(-ts_r) : ts_r[31:0];
  always_ff @(posedge clk) begin
    prod_c_r <= 64'(radius) * 64'(mag_c);
    prod_s_r <= 64'(radius) * 64'(mag_s);
    neg_c_r  <= tc_r[33];
    neg_s_r  <= ts_r[33];
  end

  // round half away from zero, saturate, apply sign
  function automatic logic [31:0] round_sat(input logic [63:0] p, input logic neg);
    logic [63:0] r;
    r = (p + (64'd1 << (SH - 1))) >> SH;
    if (neg) begin
      if (r > 64'h8000_0000) begin
        r = 64'h8000_0000;
      end
      return 32'(64'd0 - r);
    end
    if (r > 64'h7FFF_FFFF) begin
      r = 64'h7FFF_FFFF;
    end
    return r[31:0];
  endfunction

  always_ff @(posedge clk) begin
    out_z_cos <= signed'(round_sat(prod_c_r, neg_c_r));
    out_z_sin <= signed'(round_sat(prod_s_r, neg_s_r));
  end

  assign out_valid = vld_r[LAT-1];

endmodule
